// File: sv/lrukv_pkg.sv
package lrukv_pkg;

   localparam int MAX_ENTRIES_DEFAULT = 16;
   localparam int KEY_BITS_DEFAULT    = 32;
   localparam int VALUE_BITS_DEFAULT  = 32;

   localparam int CAP_BITS = 5;
   localparam int OUT_BITS = 32;

   typedef logic [CAP_BITS-1:0] cap_type;
   typedef logic [OUT_BITS-1:0] out_value_type;

   localparam cap_type CAP_RESET = CAP_BITS'(16);

   typedef enum logic {
      MODE_GET = 1'b0,
      MODE_PUT = 1'b1
   } mode_type;

endpackage

// File: sv/lrukv_if.sv
interface lrukv_req_if #(
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
);
   import lrukv_pkg::*;

   logic                  valid;
   logic                  ready;
   mode_type              mode;
   logic [KEY_BITS-1:0]   key;
   logic [VALUE_BITS-1:0] value;

   modport source (output valid, mode, key, value, input ready);
   modport sink   (input valid, mode, key, value, output ready);
endinterface

interface lrukv_rsp_if;
   import lrukv_pkg::*;

   logic          valid;
   logic          ready;
   logic          found;
   out_value_type read_value;

   modport source (output valid, found, read_value, input ready);
   modport sink   (input valid, found, read_value, output ready);
endinterface

// File: sv/lrukv_ram.sv
module lrukv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 write_enable,
   input  logic [ADDR_BITS-1:0] write_address,
   input  logic [WIDTH-1:0]     write_data,
   input  logic                 read_enable,
   input  logic [ADDR_BITS-1:0] read_address,
   output logic [WIDTH-1:0]     read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[read_address];
      end
   end

   assign read_data = read_data_ff;

endmodule

// File: sv/lru_key_value_cache_top.sv
// Fully associative key/value cache with least-recently-used replacement. Each request beat
// is a get or a put and yields exactly one response beat: found tells whether the key was
// present, read_value carries the stored value on a get hit and zero otherwise. A put on a
// new key fills the lowest free slot until the store holds the effective capacity (csr value
// clamped to 1..MAX_ENTRIES), then replaces the least recent entry. One beat is accepted per
// cycle while the response register is not stalled by rsp.ready; a beat waits in the input
// register, and its response is registered in the output register. The rate is set by the
// parallel key compare over all entries and the rank update, both combinational and applied
// together so the next beat sees the new state. Reset empties the store at once; there is no clearing pass.
module lru_key_value_cache_top #(
   parameter int MAX_ENTRIES = lrukv_pkg::MAX_ENTRIES_DEFAULT,
   parameter int KEY_BITS    = lrukv_pkg::KEY_BITS_DEFAULT,
   parameter int VALUE_BITS  = lrukv_pkg::VALUE_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  lrukv_pkg::cap_type csr_write_data,
   lrukv_req_if.sink         req,
   lrukv_rsp_if.source       rsp
);
   import lrukv_pkg::*;

   localparam int IDX_BITS  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int RANK_BITS = IDX_BITS;
   localparam int CNT_BITS  = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_BITS  = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;

   cap_type capacity_ff;

   logic                  in_valid_ff;
   mode_type              in_mode_ff;
   logic [KEY_BITS-1:0]   in_key_ff;
   logic [VALUE_BITS-1:0] in_value_ff;

   logic out_valid_ff, out_valid_in;
   logic out_found_ff;
   logic out_hit_get_ff;

   logic [MAX_ENTRIES-1:0] valid_ff, valid_in;
   logic [KEY_BITS-1:0]    key_ff  [MAX_ENTRIES];
   logic [RANK_BITS-1:0]   rank_ff [MAX_ENTRIES];
   logic [RANK_BITS-1:0]   rank_in [MAX_ENTRIES];
   logic [CNT_BITS-1:0]    count_ff, count_in;

   logic                   advance;
   logic                   is_put;
   logic                   hit;
   logic                   full;
   logic                   touch;
   logic                   insert_new;
   logic [MAX_ENTRIES-1:0] hit_oh, victim_oh, free_oh, target_oh;
   logic [RANK_BITS-1:0]   last_rank, hit_rank, old_rank;
   logic [IDX_BITS-1:0]    target_idx;
   logic [CMP_BITS-1:0]    eff_cap;

   logic [VALUE_BITS-1:0]          ram_read_data;
   logic [OUT_BITS+VALUE_BITS-1:0] value_wide;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign is_put    = (in_mode_ff == MODE_PUT);

   // effective capacity clamped to 1..MAX_ENTRIES
   always_comb begin
      if (capacity_ff == '0) begin
         eff_cap = CMP_BITS'(1);
      end else if (CMP_BITS'(capacity_ff) > CMP_BITS'(MAX_ENTRIES)) begin
         eff_cap = CMP_BITS'(MAX_ENTRIES);
      end else begin
         eff_cap = CMP_BITS'(capacity_ff);
      end
   end

   assign full      = CMP_BITS'(count_ff) >= eff_cap;
   // valid ranks are a permutation of 0..count-1, so the LRU entry holds count-1
   assign last_rank = RANK_BITS'(count_ff - 1'b1);
   assign free_oh   = ~valid_ff & (valid_ff + MAX_ENTRIES'(1));

   always_comb begin
      hit_rank = '0;
      for (int j = 0; j < MAX_ENTRIES; j++) begin
         hit_oh[j]    = valid_ff[j] && (key_ff[j] == in_key_ff);
         victim_oh[j] = valid_ff[j] && (rank_ff[j] == last_rank);
         if (hit_oh[j]) begin
            hit_rank = hit_rank | rank_ff[j];
         end
      end
      hit = |hit_oh;
   end

   always_comb begin
      if (hit) begin
         target_oh = hit_oh;
         old_rank  = hit_rank;
      end else if (full) begin
         target_oh = victim_oh;
         old_rank  = last_rank;
      end else begin
         // fill: every valid entry ages, all ranks are below count
         target_oh = free_oh;
         old_rank  = RANK_BITS'(count_ff);
      end
      target_idx = '0;
      for (int j = 0; j < MAX_ENTRIES; j++) begin
         if (target_oh[j]) begin
            target_idx = target_idx | IDX_BITS'(j);
         end
      end
   end

   assign touch      = advance && (hit || is_put);
   assign insert_new = advance && is_put && !hit;

   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      for (int j = 0; j < MAX_ENTRIES; j++) begin
         rank_in[j] = rank_ff[j];
         if (touch) begin
            if (target_oh[j]) begin
               rank_in[j] = '0;
            end else if (valid_ff[j] && (rank_ff[j] < old_rank)) begin
               rank_in[j] = rank_ff[j] + 1'b1;
            end
         end
      end
      if (insert_new && !full) begin
         valid_in = valid_ff | target_oh;
         count_in = count_ff + 1'b1;
      end
   end

   always_comb begin
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAP_RESET;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         valid_ff     <= '0;
         count_ff     <= '0;
         for (int j = 0; j < MAX_ENTRIES; j++) begin
            rank_ff[j] <= '0;
         end
      end else begin
         if (csr_write_enable) begin
            capacity_ff <= csr_write_data;
         end
         if (req.ready) begin
            in_valid_ff <= req.valid;
         end
         out_valid_ff <= out_valid_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         for (int j = 0; j < MAX_ENTRIES; j++) begin
            rank_ff[j] <= rank_in[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_mode_ff  <= req.mode;
         in_key_ff   <= req.key;
         in_value_ff <= req.value;
      end
      if (advance) begin
         out_found_ff   <= hit;
         out_hit_get_ff <= hit && !is_put;
      end
      for (int j = 0; j < MAX_ENTRIES; j++) begin
         if (insert_new && target_oh[j]) begin
            key_ff[j] <= in_key_ff;
         end
      end
   end

   // value store: put writes the target slot, get hit reads into the response register
   lrukv_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (MAX_ENTRIES)
   ) u_value_ram (
      .clock         (clock),
      .write_enable  (advance && is_put),
      .write_address (target_idx),
      .write_data    (in_value_ff),
      .read_enable   (advance && !is_put && hit),
      .read_address  (target_idx),
      .read_data     (ram_read_data)
   );

   assign value_wide     = {{OUT_BITS{1'b0}}, ram_read_data};
   assign rsp.valid      = out_valid_ff;
   assign rsp.found      = out_found_ff;
   assign rsp.read_value = out_hit_get_ff ? value_wide[OUT_BITS-1:0] : '0;

endmodule
